>>> src/kptmm_pkg.sv
// Shared types and constants for the keyed price table.
package kptmm_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam int TIME_W  = 32;
  localparam int PRICE_W = 32;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_FIN   = 4'b1000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic write;
    logic publish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic rd_pending;
    logic out_busy;
  } sts_t;

endpackage

>>> src/kptmm_ctrl.sv
// Sequencing state machine for the keyed price table.
module kptmm_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  kptmm_pkg::sts_t  sts,
  output kptmm_pkg::cmd_t  cmd
);

  kptmm_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state_r)
      kptmm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = kptmm_pkg::ST_SCAN;
        end
      end
      kptmm_pkg::ST_SCAN: begin
        cmd.issue = !sts.scan_done;
        // leave once the last read has been folded in
        if (sts.scan_done && !sts.rd_pending) begin
          state_nxt = kptmm_pkg::ST_WRITE;
        end
      end
      kptmm_pkg::ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = kptmm_pkg::ST_FIN;
      end
      kptmm_pkg::ST_FIN: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_nxt   = kptmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = kptmm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= kptmm_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> src/kptmm_dp.sv
// Table memory, scan counter, max/min/newest folding and output register.
module kptmm_dp #(
  parameter int TABLE_DEPTH = kptmm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic        [kptmm_pkg::TIME_W-1:0] in_record_time,
  input  logic signed [kptmm_pkg::PRICE_W-1:0] in_record_price,
  input  kptmm_pkg::cmd_t                     cmd,
  output kptmm_pkg::sts_t                     sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [kptmm_pkg::PRICE_W-1:0] out_latest_price,
  output logic signed [kptmm_pkg::PRICE_W-1:0] out_highest_price,
  output logic signed [kptmm_pkg::PRICE_W-1:0] out_lowest_price,
  output logic                                out_was_correction,
  output logic                                out_dropped_full
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = kptmm_pkg::TIME_W;
  localparam int PW = kptmm_pkg::PRICE_W;

  logic        [TW-1:0] mem_time  [TABLE_DEPTH];
  logic signed [PW-1:0] mem_price [TABLE_DEPTH];

  logic        [TW-1:0] t_r;
  logic signed [PW-1:0] p_r;
  logic        [CW-1:0] count_r;
  logic        [CW-1:0] idx_r;
  logic        [AW-1:0] rd_idx_r;
  logic                 rd_vld_r;
  logic        [TW-1:0] rd_time_r;
  logic signed [PW-1:0] rd_price_r;
  logic                 hit_r;
  logic        [AW-1:0] hit_idx_r;
  logic                 drop_r;
  logic                 any_r;
  logic signed [PW-1:0] hi_r, lo_r, np_r;
  logic        [TW-1:0] nt_r;
  logic                 out_valid_r;

  logic                 full;
  logic                 insert;
  logic                 wr_en;
  logic        [AW-1:0] wr_addr;
  logic                 fold_vld;
  logic        [TW-1:0] fold_t;
  logic signed [PW-1:0] fold_p;
  logic                 rd_match;

  // Entries are never removed, so slots below the fill count are exactly the valid ones.
  assign full     = (count_r == CW'(TABLE_DEPTH));
  assign insert   = !hit_r && !full;
  assign wr_en    = cmd.write && (hit_r || !full);
  assign wr_addr  = hit_r ? hit_idx_r : count_r[AW-1:0];
  assign rd_match = (rd_time_r == t_r);

  // One fold unit serves scanned entries and the newly inserted word.
  always_comb begin
    if (rd_vld_r) begin
      fold_vld = 1'b1;
      fold_t   = rd_time_r;
      fold_p   = rd_match ? p_r : rd_price_r;
    end else begin
      fold_vld = cmd.write && insert;
      fold_t   = t_r;
      fold_p   = p_r;
    end
  end

  assign sts.scan_done  = (idx_r == count_r);
  assign sts.rd_pending = rd_vld_r;
  assign sts.out_busy   = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      rd_time_r  <= mem_time[idx_r[AW-1:0]];
      rd_price_r <= mem_price[idx_r[AW-1:0]];
    end
    if (wr_en) begin
      mem_time[wr_addr]  <= t_r;
      mem_price[wr_addr] <= p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      t_r   <= in_record_time;
      p_r   <= in_record_price;
      idx_r <= '0;
      hit_r <= 1'b0;
      any_r <= 1'b0;
      hi_r  <= '0;
      lo_r  <= '0;
      nt_r  <= '0;
      np_r  <= '0;
    end else begin
      if (cmd.issue) begin
        rd_idx_r <= idx_r[AW-1:0];
        idx_r    <= idx_r + CW'(1);
      end
      if (rd_vld_r && rd_match && !hit_r) begin
        hit_r     <= 1'b1;
        hit_idx_r <= rd_idx_r;
      end
      if (fold_vld) begin
        if (!any_r) begin
          any_r <= 1'b1;
          hi_r  <= fold_p;
          lo_r  <= fold_p;
          nt_r  <= fold_t;
          np_r  <= fold_p;
        end else begin
          if (fold_p > hi_r) hi_r <= fold_p;
          if (fold_p < lo_r) lo_r <= fold_p;
          if (fold_t > nt_r) begin
            nt_r <= fold_t;
            np_r <= fold_p;
          end
        end
      end
    end
    if (cmd.write) begin
      drop_r <= !hit_r && full;
    end
    if (cmd.publish) begin
      out_latest_price   <= np_r;
      out_highest_price  <= hi_r;
      out_lowest_price   <= lo_r;
      out_was_correction <= hit_r;
      out_dropped_full   <= drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      if (cmd.write && insert) begin
        count_r <= count_r + CW'(1);
      end
      if (cmd.publish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/keyed_price_table_max_min_unit.sv
// Keyed price table: per record, the price at the newest timestamp and the max/min price.
// The scan reads each stored entry through the single read port of the table memory, and a
// new word is accepted only once the previous result has been published; a stalled result
// word holds the next one back.
// Reset: synchronous, active low; empties the table by clearing its fill count (no sweep).
module keyed_price_table_max_min_unit #(
  parameter int TABLE_DEPTH = kptmm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic        [kptmm_pkg::TIME_W-1:0]  in_record_time,
  input  logic signed [kptmm_pkg::PRICE_W-1:0] in_record_price,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [kptmm_pkg::PRICE_W-1:0] out_latest_price,
  output logic signed [kptmm_pkg::PRICE_W-1:0] out_highest_price,
  output logic signed [kptmm_pkg::PRICE_W-1:0] out_lowest_price,
  output logic                                 out_was_correction,
  output logic                                 out_dropped_full
);

  kptmm_pkg::cmd_t cmd;
  kptmm_pkg::sts_t sts;

  kptmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kptmm_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_record_time     (in_record_time),
    .in_record_price    (in_record_price),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_latest_price   (out_latest_price),
    .out_highest_price  (out_highest_price),
    .out_lowest_price   (out_lowest_price),
    .out_was_correction (out_was_correction),
    .out_dropped_full   (out_dropped_full)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a word is in flight");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.issue, cmd.write, cmd.publish}))
    else $error("controller issued more than one command");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |-> !(out_valid && out_stall))
    else $error("result published over a stalled word");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_was_correction && out_dropped_full))
    else $error("correction and drop flagged together");

endmodule

>>> dv/keyed_price_table_max_min_unit_tb.sv
// Testbench for the keyed price table: random and directed price records, scoreboard check.
module keyed_price_table_max_min_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BOOK_DEPTH = kptmm_pkg::TABLE_DEPTH_DEF;
  localparam int RANDOM_TICKS = 1434;

  typedef struct {
    logic        [31:0] stamp;
    logic signed [31:0] price;
  } tick_t;

  typedef struct {
    logic signed [31:0] latest;
    logic signed [31:0] highest;
    logic signed [31:0] lowest;
    logic               correction;
    logic               dropped;
  } quote_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic        [kptmm_pkg::TIME_W-1:0]  in_record_time = '0;
  logic signed [kptmm_pkg::PRICE_W-1:0] in_record_price = '0;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic signed [kptmm_pkg::PRICE_W-1:0] out_latest_price;
  logic signed [kptmm_pkg::PRICE_W-1:0] out_highest_price;
  logic signed [kptmm_pkg::PRICE_W-1:0] out_lowest_price;
  logic                             out_was_correction;
  logic                             out_dropped_full;

  // Shadow copy of the price book
  logic               book_used  [BOOK_DEPTH];
  logic        [31:0] book_stamp [BOOK_DEPTH];
  logic signed [31:0] book_price [BOOK_DEPTH];

  tick_t  ticks_pending[$];
  quote_t quotes_due[$];
  int     n_sent = 0;
  int     mismatches = 0;
  int     send_idle;
  int     recv_idle;
  int     hold_left = 0;
  int     holds_done = 0;

  keyed_price_table_max_min_unit #(
    .TABLE_DEPTH(BOOK_DEPTH)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_record_time    (in_record_time),
    .in_record_price   (in_record_price),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_latest_price  (out_latest_price),
    .out_highest_price (out_highest_price),
    .out_lowest_price  (out_lowest_price),
    .out_was_correction(out_was_correction),
    .out_dropped_full  (out_dropped_full)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one record to the shadow book and return the quote it produces.
  function automatic quote_t book_record(input logic [31:0] stamp,
                                         input logic signed [31:0] price);
    quote_t      q;
    int          hit;
    int          free;
    bit          seen;
    logic [31:0] newest;
    hit    = -1;
    free   = -1;
    seen   = 1'b0;
    newest = '0;
    q      = '{default: '0};
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      if (book_used[i]) begin
        if (hit < 0 && book_stamp[i] == stamp) hit = i;
      end else if (free < 0) begin
        free = i;
      end
    end
    if (hit >= 0) begin
      book_price[hit] = price;
      q.correction = 1'b1;
    end else if (free >= 0) begin
      book_used[free]  = 1'b1;
      book_stamp[free] = stamp;
      book_price[free] = price;
    end else begin
      q.dropped = 1'b1;
    end
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      if (book_used[i]) begin
        if (!seen) begin
          seen = 1'b1;
          q.highest = book_price[i];
          q.lowest  = book_price[i];
          q.latest  = book_price[i];
          newest    = book_stamp[i];
        end else begin
          if (book_price[i] > q.highest) q.highest = book_price[i];
          if (book_price[i] < q.lowest) q.lowest = book_price[i];
          if (book_stamp[i] > newest) begin
            newest   = book_stamp[i];
            q.latest = book_price[i];
          end
        end
      end
    end
    return q;
  endfunction

  function automatic logic signed [31:0] pick_price();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2, 3:    return $urandom_range(20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_stamp();
    case ($urandom_range(9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'hFFFF_FF00 + $urandom_range(255);
      3:       return $urandom_range(255);
      default: return $urandom;
    endcase
  endfunction

  // Idle rates per phase: sender-light, then receiver-light, then none.
  always_comb begin
    if (n_sent < 480) begin
      send_idle = 34;
      recv_idle = 71;
    end else if (n_sent < 960) begin
      send_idle = 71;
      recv_idle = 34;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
  end

  always @(posedge clk) begin : drive_ticks
    tick_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        quotes_due.push_back(book_record(in_record_time, in_record_price));
        n_sent <= n_sent + 1;
      end
      // hold a stalled word, otherwise offer the next one or idle
      if (!in_valid || !in_stall) begin
        if (ticks_pending.size() != 0 && $urandom_range(99) >= send_idle) begin
          nxt = ticks_pending.pop_front();
          in_valid        <= 1'b1;
          in_record_time  <= nxt.stamp;
          in_record_price <= nxt.price;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus two long hold-offs that back up the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if ((holds_done == 0 && n_sent >= 150) || (holds_done == 1 && n_sent >= 1100)) begin
      out_stall  <= 1'b1;
      hold_left  <= 600;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t %s mismatch: expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_quotes
    quote_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (quotes_due.size() == 0) begin
        $display("%0t unexpected word: expected none, got latest %h high %h low %h",
                 $time, out_latest_price, out_highest_price, out_lowest_price);
        mismatches++;
      end else begin
        want = quotes_due.pop_front();
        check_field("latest_price", want.latest, out_latest_price);
        check_field("highest_price", want.highest, out_highest_price);
        check_field("lowest_price", want.lowest, out_lowest_price);
        check_field("was_correction", {31'b0, want.correction}, {31'b0, out_was_correction});
        check_field("dropped_full", {31'b0, want.dropped}, {31'b0, out_dropped_full});
      end
    end
  end

  initial begin
    #8_000_000;
    $display("[keyed_price_table_max_min_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] stamp_pool[$];
    logic [31:0] stamp;
    int          new_pct;
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      book_used[i]  = 1'b0;
      book_stamp[i] = '0;
      book_price[i] = '0;
    end

    // Directed: first record, out-of-order stamps, corrections, field extremes, ties.
    ticks_pending.push_back('{32'd100, 32'sd0});
    ticks_pending.push_back('{32'd50, -32'sd5});
    ticks_pending.push_back('{32'd100, 32'sd7});
    ticks_pending.push_back('{32'h0000_0000, 32'sh8000_0000});
    ticks_pending.push_back('{32'hFFFF_FFFF, 32'sh7FFF_FFFF});
    ticks_pending.push_back('{32'hFFFF_FFFF, 32'sh8000_0000});
    ticks_pending.push_back('{32'h0000_0000, 32'sh7FFF_FFFF});
    ticks_pending.push_back('{32'd200, -32'sd1});
    ticks_pending.push_back('{32'd50, 32'sd1});
    ticks_pending.push_back('{32'hAAAA_AAAA, 32'sh5555_5555});
    ticks_pending.push_back('{32'h5555_5555, 32'shAAAA_AAAA});
    ticks_pending.push_back('{32'h8000_0000, 32'sd0});
    ticks_pending.push_back('{32'h7FFF_FFFF, -32'sd2});
    ticks_pending.push_back('{32'hFFFF_FFFE, 32'sd3});
    ticks_pending.push_back('{32'd200, 32'sh8000_0000});
    ticks_pending.push_back('{32'd100, 32'sh7FFF_FFFF});
    stamp_pool = '{32'd100, 32'd50, 32'h0, 32'hFFFF_FFFF, 32'd200, 32'hAAAA_AAAA,
                   32'h5555_5555, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFE};

    // Random: fill the book slowly, then mostly corrections with dropped new stamps mixed in.
    for (int k = 0; k < RANDOM_TICKS; k++) begin
      new_pct = (k < 300) ? 20 : 30;
      if ($urandom_range(99) < new_pct) begin
        stamp = pick_stamp();
        stamp_pool.push_back(stamp);
      end else begin
        stamp = stamp_pool[$urandom_range(stamp_pool.size() - 1)];
      end
      ticks_pending.push_back('{stamp, pick_price()});
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all words sent and every quote returned.
    @(negedge clk);
    while (ticks_pending.size() != 0 || in_valid || quotes_due.size() != 0) @(negedge clk);
    repeat (80) @(posedge clk);
    if (mismatches == 0) begin
      $display("[keyed_price_table_max_min_unit] OK");
    end else begin
      $display("[keyed_price_table_max_min_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/kptmm_pkg.sv
src/kptmm_ctrl.sv
src/kptmm_dp.sv
src/keyed_price_table_max_min_unit.sv
dv/keyed_price_table_max_min_unit_tb.sv
